@@ hw/rtl/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; imported by every module of the block except rmq_div.
`default_nettype none

package rmq_pkg;

    // Normalized magnitudes live in [2^29, 2^30)
    localparam int NORM_BITS = 30;
    localparam logic [5:0] NORM_TOP = 6'd29;
    // Sum of four squares of normalized magnitudes, and its root
    localparam int SUM_W  = 2 * NORM_BITS + 2;
    localparam int ROOT_W = NORM_BITS + 1;
    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Classification carried along with each matrix
    typedef struct packed {
        logic       degen;  // radicand not positive: identity result
        logic [3:0] neg;    // sign of x, y, z, w
    } t_cls;

    // Magnitude width for the signed vector (r, d1, d2, d3)
    function automatic int mag_width(input int dw, input int fb);
        mag_width = ((dw > fb) ? dw : fb) + 3;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// Rotation matrix (Q2.14 by default) to unit quaternion, Shepperd's method.
// Depends on rmq_pkg, rmq_front, rmq_fifo, rmq_back.
//
// Takes one 3x3 matrix per transaction and returns the normalized quaternion
// (x, y, z, w) with a degenerate flag; a non-positive radicand yields the
// identity with the flag set. The block accepts one matrix every clock cycle
// and keeps that rate as long as results are popped. A result passes through
// six stages of normalize and sum of squares, a 31-stage square root, a
// FRAC_BITS + 1 stage divider per component and the output register. A
// two-entry queue behind the input absorbs pushes while the output waits;
// the pipeline stalls as a whole when the output register holds an unpopped
// result.
`default_nettype none

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output      logic                         full,
    input  wire logic signed [DATA_WIDTH-1:0] i_m00,
    input  wire logic signed [DATA_WIDTH-1:0] i_m01,
    input  wire logic signed [DATA_WIDTH-1:0] i_m02,
    input  wire logic signed [DATA_WIDTH-1:0] i_m10,
    input  wire logic signed [DATA_WIDTH-1:0] i_m11,
    input  wire logic signed [DATA_WIDTH-1:0] i_m12,
    input  wire logic signed [DATA_WIDTH-1:0] i_m20,
    input  wire logic signed [DATA_WIDTH-1:0] i_m21,
    input  wire logic signed [DATA_WIDTH-1:0] i_m22,
    output      logic                         empty,
    input  wire logic                         pop,
    output      logic signed [DATA_WIDTH-1:0] o_quat_x,
    output      logic signed [DATA_WIDTH-1:0] o_quat_y,
    output      logic signed [DATA_WIDTH-1:0] o_quat_z,
    output      logic signed [DATA_WIDTH-1:0] o_quat_w,
    output      logic                         o_degenerate
);

    localparam int MAGW = mag_width(DATA_WIDTH, FRAC_BITS);
    localparam int CLSW = $bits(t_cls);
    localparam int QWID = CLSW + 4 * MAGW;

    logic signed [DATA_WIDTH-1:0] m [9];
    logic [MAGW-1:0]              f_mag [4];
    t_cls                         f_cls;
    logic [QWID-1:0]              q_wdata, q_rdata;
    logic                         q_empty, q_pop;
    logic [MAGW-1:0]              b_mag [4];
    t_cls                         b_cls;
    logic [DATA_WIDTH-1:0]        quat [4];

    assign m[0] = i_m00;
    assign m[1] = i_m01;
    assign m[2] = i_m02;
    assign m[3] = i_m10;
    assign m[4] = i_m11;
    assign m[5] = i_m12;
    assign m[6] = i_m20;
    assign m[7] = i_m21;
    assign m[8] = i_m22;

    rmq_front #(
        .DW (DATA_WIDTH),
        .FB (FRAC_BITS)
    ) u_front (
        .i_m   (m),
        .o_mag (f_mag),
        .o_cls (f_cls)
    );

    // queue word: classification on top, then w, z, y, x magnitudes
    assign q_wdata = {f_cls, f_mag[3], f_mag[2], f_mag[1], f_mag[0]};

    rmq_fifo #(
        .WIDTH (QWID)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (q_wdata),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            b_mag[i] = q_rdata[i*MAGW +: MAGW];
        end
        b_cls = q_rdata[QWID-1 -: CLSW];
    end

    rmq_back #(
        .DW (DATA_WIDTH),
        .FB (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_mag     (b_mag),
        .i_cls     (b_cls),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_quat    (quat),
        .o_degen   (o_degenerate)
    );

    assign o_quat_x = quat[0];
    assign o_quat_y = quat[1];
    assign o_quat_z = quat[2];
    assign o_quat_w = quat[3];

endmodule

`default_nettype wire

@@ hw/rtl/rmq_front.sv @@
// Front end: picks the Shepperd branch and forms the unnormalized vector.
// Depends on rmq_pkg. Purely combinational, feeds the queue.
`default_nettype none

module rmq_front
    import rmq_pkg::*;
#(
    parameter int DW = 16,
    parameter int FB = 14
) (
    input  wire logic signed [DW-1:0]                  i_m   [9],
    output      logic        [mag_width(DW, FB)-1:0]   o_mag [4],
    output      t_cls                                  o_cls
);

    localparam int MAGW = mag_width(DW, FB);
    localparam int VW   = MAGW + 1;
    localparam logic signed [VW-1:0] ONE_Q = VW'(1) <<< FB;

    typedef enum logic [1:0] {BR_TRACE, BR_X, BR_Y, BR_Z} t_branch;

    logic signed [VW-1:0] a [9];
    logic signed [VW-1:0] tr, r, dx, dy, dz, sxy, sxz, syz;
    logic signed [VW-1:0] v [4];
    logic signed [VW-1:0] av;
    t_branch              br;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            a[i] = VW'(i_m[i]);
        end
        tr  = a[0] + a[4] + a[8];
        dx  = a[7] - a[5];
        dy  = a[2] - a[6];
        dz  = a[3] - a[1];
        sxy = a[1] + a[3];
        sxz = a[2] + a[6];
        syz = a[5] + a[7];

        // branch choice: positive trace first, then the largest diagonal element
        priority if (!tr[VW-1] && (tr != '0)) begin
            br = BR_TRACE;
        end else if ((a[0] > a[4]) && (a[0] > a[8])) begin
            br = BR_X;
        end else if (a[4] > a[8]) begin
            br = BR_Y;
        end else begin
            br = BR_Z;
        end

        unique case (br)
            BR_TRACE: begin
                r = tr + ONE_Q;
                v[0] = dx;  v[1] = dy;  v[2] = dz;  v[3] = r;
            end
            BR_X: begin
                r = ONE_Q + a[0] - a[4] - a[8];
                v[0] = r;   v[1] = sxy; v[2] = sxz; v[3] = dx;
            end
            BR_Y: begin
                r = ONE_Q + a[4] - a[0] - a[8];
                v[0] = sxy; v[1] = r;   v[2] = syz; v[3] = dy;
            end
            default: begin
                r = ONE_Q + a[8] - a[0] - a[4];
                v[0] = sxz; v[1] = syz; v[2] = r;   v[3] = dz;
            end
        endcase

        o_cls.degen = r[VW-1] || (r == '0);
        for (int i = 0; i < 4; i++) begin
            o_cls.neg[i] = v[i][VW-1];
            av           = v[i][VW-1] ? -v[i] : v[i];
            o_mag[i]     = av[MAGW-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rmq_fifo.sv @@
// Short queue between front and back; holds classified transactions.
// Depends on rmq_pkg for its depth.
`default_nettype none

module rmq_fifo
    import rmq_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output      logic             o_full,
    input  wire logic             i_pop,
    output      logic [WIDTH-1:0] o_rdata,
    output      logic             o_empty
);

    localparam int PTW = $clog2(QUEUE_DEPTH);
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNW-1:0]   r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + PTW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + PTW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_count > CNW'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !rd_en |=> (r_count == CNW'(QUEUE_DEPTH)))
        else $error("queue lost an entry while full");

endmodule

`default_nettype wire

@@ hw/rtl/rmq_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// No package dependency; the back end instantiates one per component.
`default_nettype none

module rmq_div #(
    parameter int NUM_W = 45,
    parameter int QUO_W = 15,
    parameter int DEN_W = 31
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output      logic [QUO_W-1:0] o_quo
);

    // the high numerator part is known to be below the divisor
    logic [DEN_W-1:0] rem_in [QUO_W];
    logic [NUM_W-1:0] num_in [QUO_W];
    logic [DEN_W-1:0] den_in [QUO_W];
    logic [QUO_W-1:0] quo_in [QUO_W];

    logic [DEN_W-1:0] r_rem [QUO_W-1];
    logic [NUM_W-1:0] r_num [QUO_W-1];
    logic [DEN_W-1:0] r_den [QUO_W-1];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic [DEN_W:0] t;
        logic           ge;

        if (j == 0) begin : g_first
            assign rem_in[j] = DEN_W'(i_num >> QUO_W);
            assign num_in[j] = i_num;
            assign den_in[j] = i_den;
            assign quo_in[j] = '0;
        end else begin : g_next
            assign rem_in[j] = r_rem[j-1];
            assign num_in[j] = r_num[j-1];
            assign den_in[j] = r_den[j-1];
            assign quo_in[j] = r_quo[j-1];
        end

        // shift in the next numerator bit and try a subtract
        assign t  = {rem_in[j], num_in[j][QUO_W-1-j]};
        assign ge = (t >= {1'b0, den_in[j]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= {quo_in[j][QUO_W-2:0], ge};
            end
        end

        if (j < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= ge ? DEN_W'(t - {1'b0, den_in[j]}) : DEN_W'(t);
                    r_num[j] <= num_in[j];
                    r_den[j] <= den_in[j];
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/rmq_back.sv @@
// Back end: normalize, sum of squares, square root, divide, output register.
// Depends on rmq_pkg and rmq_div.
`default_nettype none

module rmq_back
    import rmq_pkg::*;
#(
    parameter int DW = 16,
    parameter int FB = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_empty,
    input  wire logic [mag_width(DW, FB)-1:0]  i_mag [4],
    input  wire t_cls                          i_cls,
    output      logic                          o_q_pop,
    output      logic                          o_empty,
    input  wire logic                          i_pop,
    output      logic [DW-1:0]                 o_quat [4],
    output      logic                          o_degen
);

    localparam int MAGW = mag_width(DW, FB);
    localparam int PW   = $clog2(MAGW);
    localparam int WW   = MAGW + NORM_BITS;
    localparam int SQW  = 2 * NORM_BITS;
    localparam int PSW  = SQW + 1;
    localparam int TW   = SUM_W + 1;
    localparam int QW   = FB + 1;
    localparam int NW   = NORM_BITS + QW;
    localparam int CW   = ((QW > DW) ? QW : DW) + 1;
    localparam logic [CW-1:0] POS_MAX = CW'((64'(1) << (DW - 1)) - 64'(1));
    localparam logic [DW-1:0] ONE_OUT =
        (FB >= DW - 1) ? POS_MAX[DW-1:0] : DW'(64'(1) << FB);

    logic en;

    // stage A: capture, stage B: leading one, stage C: shift
    logic                 r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld;
    t_cls                 r_a_cls, r_b_cls, r_c_cls, r_d_cls, r_e_cls;
    logic [MAGW-1:0]      r_a_mag [4];
    logic [MAGW-1:0]      r_a_or;
    logic [MAGW-1:0]      r_b_mag [4];
    logic [PW-1:0]        r_b_pos;
    logic [NORM_BITS-1:0] r_c_nm [4];
    logic [NORM_BITS-1:0] r_d_nm [4];
    logic [SQW-1:0]       r_d_sq [4];
    logic [NORM_BITS-1:0] r_e_nm [4];
    logic [PSW-1:0]       r_e_p0, r_e_p1;

    // square root pipeline, element 0 holds the sum
    logic                 r_s_vld  [ROOT_W+1];
    t_cls                 r_s_cls  [ROOT_W+1];
    logic [NORM_BITS-1:0] r_s_nm   [ROOT_W+1][4];
    logic [TW-1:0]        r_s_rem  [ROOT_W];
    logic [ROOT_W-1:0]    r_s_root [ROOT_W+1];

    // numerators, divider side line, output
    logic                 r_g_vld;
    t_cls                 r_g_cls;
    logic [NW-1:0]        r_g_num [4];
    logic [ROOT_W-1:0]    r_g_root;
    logic                 r_dl_vld [QW];
    t_cls                 r_dl_cls [QW];
    logic [QW-1:0]        quo [4];
    logic                 r_out_vld;
    logic [DW-1:0]        r_out_quat [4];
    logic                 r_out_degen;

    logic [PW-1:0]        pos;
    logic [5:0]           pos6, lsh, rsh;
    logic [WW-1:0]        wide [4];
    logic [CW-1:0]        cq, cres;
    logic [DW-1:0]        n_quat [4];

    // whole pipeline advances unless a result waits unclaimed
    assign en      = !r_out_vld || i_pop;
    assign o_q_pop = en && !i_q_empty;

    // leading one of the OR of all magnitudes equals that of the largest
    always_comb begin
        pos = '0;
        for (int b = 0; b < MAGW; b++) begin
            if (r_a_or[b]) begin
                pos = PW'(b);
            end
        end
    end

    // shift all four together so the largest lands in [2^29, 2^30)
    always_comb begin
        pos6 = 6'(r_b_pos);
        if (pos6 >= NORM_TOP) begin
            rsh = pos6 - NORM_TOP;
            lsh = '0;
        end else begin
            rsh = '0;
            lsh = NORM_TOP - pos6;
        end
        for (int i = 0; i < 4; i++) begin
            wide[i] = ({{NORM_BITS{1'b0}}, r_b_mag[i]} << lsh) >> rsh;
        end
    end

    // front stages payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mag <= i_mag;
            r_a_cls <= i_cls;
            r_a_or  <= i_mag[0] | i_mag[1] | i_mag[2] | i_mag[3];
            r_b_mag <= r_a_mag;
            r_b_cls <= r_a_cls;
            r_b_pos <= pos;
            r_c_cls <= r_b_cls;
            for (int i = 0; i < 4; i++) begin
                r_c_nm[i] <= wide[i][NORM_BITS-1:0];
                r_d_sq[i] <= r_c_nm[i] * r_c_nm[i];
            end
            r_d_nm  <= r_c_nm;
            r_d_cls <= r_c_cls;
            r_e_p0  <= PSW'(r_d_sq[0]) + PSW'(r_d_sq[1]);
            r_e_p1  <= PSW'(r_d_sq[2]) + PSW'(r_d_sq[3]);
            r_e_nm  <= r_d_nm;
            r_e_cls <= r_d_cls;
            r_s_rem[0]  <= TW'(SUM_W'(r_e_p0) + SUM_W'(r_e_p1));
            r_s_root[0] <= '0;
            r_s_nm[0]   <= r_e_nm;
            r_s_cls[0]  <= r_e_cls;
        end
    end

    // bit-per-stage floor square root
    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int K = ROOT_W - 1 - j;
        logic [TW-1:0] test;
        logic          take;

        assign test = (TW'(r_s_root[j]) << (K + 1)) + (TW'(1) << (2 * K));
        assign take = (r_s_rem[j] >= test);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_root[j+1] <= take ? (r_s_root[j] | (ROOT_W'(1) << K)) : r_s_root[j];
                r_s_nm[j+1]   <= r_s_nm[j];
                r_s_cls[j+1]  <= r_s_cls[j];
            end
        end

        if (j < ROOT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_s_rem[j+1] <= take ? (r_s_rem[j] - test) : r_s_rem[j];
                end
            end
        end
    end

    // rounded numerators: mag * 2^FB + root/2, divisor kept beside them
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_cls  <= r_s_cls[ROOT_W];
            r_g_root <= r_s_root[ROOT_W];
            for (int i = 0; i < 4; i++) begin
                r_g_num[i] <= (NW'(r_s_nm[ROOT_W][i]) << FB)
                            + NW'(r_s_root[ROOT_W] >> 1);
            end
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_div
        rmq_div #(
            .NUM_W (NW),
            .QUO_W (QW),
            .DEN_W (ROOT_W)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_g_num[i]),
            .i_den (r_g_root),
            .o_quo (quo[i])
        );
    end

    // divider side line for classification
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_cls[0] <= r_g_cls;
            for (int k = 1; k < QW; k++) begin
                r_dl_cls[k] <= r_dl_cls[k-1];
            end
        end
    end

    // apply sign, saturate high, substitute identity when degenerate
    always_comb begin
        cq   = '0;
        cres = '0;
        for (int i = 0; i < 4; i++) begin
            cq   = CW'(quo[i]);
            cres = r_dl_cls[QW-1].neg[i] ? -cq : ((cq > POS_MAX) ? POS_MAX : cq);
            n_quat[i] = cres[DW-1:0];
        end
        if (r_dl_cls[QW-1].degen) begin
            n_quat[0] = '0;
            n_quat[1] = '0;
            n_quat[2] = '0;
            n_quat[3] = ONE_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_quat  <= n_quat;
            r_out_degen <= r_dl_cls[QW-1].degen;
        end
    end

    // valid bits along the whole pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= ROOT_W; k++) begin
                r_s_vld[k] <= 1'b0;
            end
            for (int k = 0; k < QW; k++) begin
                r_dl_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_a_vld    <= !i_q_empty;
            r_b_vld    <= r_a_vld;
            r_c_vld    <= r_b_vld;
            r_d_vld    <= r_c_vld;
            r_e_vld    <= r_d_vld;
            r_s_vld[0] <= r_e_vld;
            for (int k = 1; k <= ROOT_W; k++) begin
                r_s_vld[k] <= r_s_vld[k-1];
            end
            r_g_vld     <= r_s_vld[ROOT_W];
            r_dl_vld[0] <= r_g_vld;
            for (int k = 1; k < QW; k++) begin
                r_dl_vld[k] <= r_dl_vld[k-1];
            end
            r_out_vld <= r_dl_vld[QW-1];
        end
    end

    assign o_empty = !r_out_vld;
    assign o_quat  = r_out_quat;
    assign o_degen = r_out_degen;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_pop |=> r_out_vld && $stable(r_out_degen))
        else $error("waiting result dropped or changed");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_vld[ROOT_W] && !r_s_cls[ROOT_W].degen |->
            (r_s_root[ROOT_W][ROOT_W-1:NORM_BITS-1] != '0))
        else $error("vector length below normalized range");

    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_degen |->
            (r_out_quat[0] == '0) && (r_out_quat[1] == '0) && (r_out_quat[2] == '0))
        else $error("degenerate result not the identity");

endmodule

`default_nettype wire
